@@ src/hwt_pkg.sv @@
// Shared types and constants for the hierarchy world-transform block.
// Used by every module under src; no dependencies of its own.
`default_nettype none

package hwt_pkg;

    localparam int NodeW       = 8;
    localparam int ColW        = 2;
    localparam int ElemW       = 32;
    localparam int Rows        = 4;
    localparam int FracW       = 16;
    localparam int ProdW       = 2 * ElemW;
    localparam int SumW        = ProdW + 2;
    localparam int DefMaxNodes = 256;
    localparam int STdataW     = 152;
    localparam int MTdataW     = 144;

    localparam logic [ElemW-1:0] One  = ElemW'(1) << FracW;
    localparam logic [ElemW-1:0] MaxQ = {1'b0, {(ElemW-1){1'b1}}};
    localparam logic [ElemW-1:0] MinQ = {1'b1, {(ElemW-1){1'b0}}};

    // one column, row 0 in the lowest bits
    typedef logic [Rows-1:0][ElemW-1:0] t_col;
    // full matrix, indexed [column][row]
    typedef logic [Rows-1:0][Rows-1:0][ElemW-1:0] t_mat;
    // products, indexed [row][column of parent]
    typedef logic [Rows-1:0][Rows-1:0][ProdW-1:0] t_prod;

    typedef struct packed {
        t_col            rows;
        logic [ColW-1:0] col;
        logic [NodeW-1:0] parent;
        logic [NodeW-1:0] node;
    } t_s_item;

    typedef struct packed {
        t_col             rows;
        logic [ColW-1:0]  col;
        logic [NodeW-1:0] node;
    } t_m_item;

    typedef struct packed {
        logic             valid;
        logic [NodeW-1:0] node;
        logic [ColW-1:0]  col;
        t_col             data;
    } t_fwd;

    typedef struct packed {
        logic root;
        logic pvalid;
    } t_opsel;

    typedef struct packed {
        logic            en;
        logic [ColW-1:0] col;
    } t_wr_ctl;

endpackage

`default_nettype wire

@@ src/hwt_store.sv @@
// World matrix store: four column banks addressed by node, registered reads,
// and the zeroing sweep after reset. Depends on hwt_pkg.
`default_nettype none

module hwt_store #(
    parameter int  MAX_NODES = hwt_pkg::DefMaxNodes,
    localparam int AW        = $clog2(MAX_NODES)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    input  hwt_pkg::t_wr_ctl i_wr,
    input  logic [AW-1:0]    i_wr_addr,
    input  hwt_pkg::t_col    i_wr_data,
    output hwt_pkg::t_mat    o_rd_data,
    output logic             o_busy
);
    import hwt_pkg::*;

    logic          r_busy;
    logic [AW-1:0] r_clr;
    logic [AW-1:0] wr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_clr  <= '0;
        end else if (r_busy) begin
            r_clr <= r_clr + 1'b1;
            if (r_clr == AW'(MAX_NODES - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign wr_addr = r_busy ? r_clr : i_wr_addr;
    assign o_busy  = r_busy;

    for (genvar b = 0; b < Rows; b++) begin : g_bank
        t_col r_mem [MAX_NODES];
        t_col r_rd;

        always_ff @(posedge i_clk) begin
            if (r_busy || (i_wr.en && i_wr.col == ColW'(b))) begin
                r_mem[wr_addr] <= r_busy ? '0 : i_wr_data;
            end
            if (i_rd_en) begin
                r_rd <= r_mem[i_rd_addr];
            end
        end

        assign o_rd_data[b] = r_rd;
    end

endmodule

`default_nettype wire

@@ src/hwt_mult.sv @@
// Operand selection (identity, zero, forwarded column or stored matrix) and the
// sixteen registered 32x32 products. Depends on hwt_pkg.
`default_nettype none

module hwt_mult (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  hwt_pkg::t_mat              i_mat,
    input  hwt_pkg::t_fwd              i_fwd,
    input  logic [hwt_pkg::NodeW-1:0]  i_parent,
    input  hwt_pkg::t_opsel            i_sel,
    input  hwt_pkg::t_col              i_local,
    output hwt_pkg::t_prod             o_prod
);
    import hwt_pkg::*;

    t_mat  opnd;
    t_prod n_prod;
    t_prod r_prod;

    always_comb begin
        for (int k = 0; k < Rows; k++) begin
            for (int r = 0; r < Rows; r++) begin
                if (i_sel.root) begin
                    opnd[k][r] = (k == r) ? One : '0;
                end else if (!i_sel.pvalid) begin
                    opnd[k][r] = '0;
                end else if (i_fwd.valid && i_fwd.node == i_parent
                             && i_fwd.col == ColW'(k)) begin
                    opnd[k][r] = i_fwd.data[r];
                end else begin
                    opnd[k][r] = i_mat[k][r];
                end
            end
        end
    end

    always_comb begin
        for (int r = 0; r < Rows; r++) begin
            for (int k = 0; k < Rows; k++) begin
                n_prod[r][k] = $signed(opnd[k][r]) * $signed(i_local[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

@@ src/hwt_sat.sv @@
// Dot-product reduction: exact sum of four products per row, floor shift by the
// fraction width and saturation to 32 bits. Depends on hwt_pkg.
`default_nettype none

module hwt_sat (
    input  hwt_pkg::t_prod i_prod,
    output hwt_pkg::t_col  o_world,
    output logic           o_sat
);
    import hwt_pkg::*;

    logic signed [SumW-1:0] sum [Rows];

    always_comb begin
        o_sat = 1'b0;
        for (int r = 0; r < Rows; r++) begin
            sum[r] = '0;
            for (int k = 0; k < Rows; k++) begin
                sum[r] = sum[r] + $signed(i_prod[r][k]);
            end
            if ((&sum[r][SumW-1:FracW+ElemW-1]) || !(|sum[r][SumW-1:FracW+ElemW-1])) begin
                o_world[r] = sum[r][FracW+ElemW-1:FracW];
            end else begin
                o_sat      = 1'b1;
                o_world[r] = sum[r][SumW-1] ? MinQ : MaxQ;
            end
        end
    end

endmodule

`default_nettype wire

@@ src/hierarchy_world_transform.sv @@
// Scene-hierarchy world transform update. One word carries one column of a
// node's local Q16.16 matrix; the block multiplies it by the stored world
// matrix of the parent (node 0 passes through), stores the result as the
// node's world column and returns it with a saturation flag. Three pipeline
// registers (parent read, products, result) carry each word to the output at
// one column per cycle unless the output stalls; a column whose parent is the
// node of the column accepted directly before it waits for that column's
// store write. After reset the world store is swept to zero, one node per
// cycle, and no word is taken until the sweep is done.
// Depends on hwt_pkg, hwt_store, hwt_mult and hwt_sat.
`default_nettype none

module hierarchy_world_transform #(
    parameter int MAX_NODES = hwt_pkg::DefMaxNodes
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // node_index, parent_index, column_index, local_row0..local_row3
    input  logic [hwt_pkg::STdataW-1:0]  s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // out_node, out_column, world_row0..world_row3
    output logic [hwt_pkg::MTdataW-1:0]  m_tdata,
    // saturated
    output logic                         m_tuser
);
    import hwt_pkg::*;

    localparam int AW = $clog2(MAX_NODES);

    t_s_item          in_item;
    logic             accept;
    logic             busy;
    logic             out_free;
    logic             p_move;
    logic             p_free;
    logic             a_move;
    logic             a_free;
    logic             hazard;
    logic             reread;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    t_wr_ctl          wr;
    t_mat             rd_data;
    t_prod            prod;
    t_col             world;
    logic             sat;

    logic             r_a_valid, n_a_valid;
    logic [NodeW-1:0] r_a_node;
    logic [NodeW-1:0] r_a_parent;
    logic [ColW-1:0]  r_a_col;
    t_col             r_a_local;
    t_opsel           r_a_sel;
    logic             r_a_wr;

    logic             r_p_valid, n_p_valid;
    logic [NodeW-1:0] r_p_node;
    logic [ColW-1:0]  r_p_col;
    logic             r_p_wr;

    logic             r_out_valid, n_out_valid;
    t_m_item          r_out;
    logic             r_out_sat;

    logic             r_wb_valid;
    logic [NodeW-1:0] r_wb_node;
    logic [ColW-1:0]  r_wb_col;
    t_col             r_wb_data;
    t_fwd             fwd;

    assign in_item  = t_s_item'(s_tdata[$bits(t_s_item)-1:0]);

    assign out_free = !r_out_valid || m_tready;
    assign p_move   = r_p_valid && out_free;
    assign p_free   = !r_p_valid || out_free;
    assign hazard   = r_a_valid && !r_a_sel.root && r_a_sel.pvalid
                      && r_p_valid && r_p_wr && r_p_node == r_a_parent;
    assign a_move   = r_a_valid && p_free && !hazard;
    assign a_free   = !r_a_valid || a_move;
    assign s_tready = a_free && !busy;
    assign accept   = s_tvalid && s_tready;
    assign reread   = hazard && p_move;
    assign rd_en    = accept || reread;
    assign rd_addr  = reread ? AW'(r_a_parent) : AW'(in_item.parent);

    assign wr.en    = p_move && r_p_wr;
    assign wr.col   = r_p_col;

    assign n_a_valid   = accept ? 1'b1 : (a_move ? 1'b0 : r_a_valid);
    assign n_p_valid   = a_move ? 1'b1 : (p_move ? 1'b0 : r_p_valid);
    assign n_out_valid = p_move || (r_out_valid && !m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_wb_valid  <= 1'b0;
        end else begin
            r_a_valid   <= n_a_valid;
            r_p_valid   <= n_p_valid;
            r_out_valid <= n_out_valid;
            if (wr.en) begin
                r_wb_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_node         <= in_item.node;
            r_a_parent       <= in_item.parent;
            r_a_col          <= in_item.col;
            r_a_local        <= in_item.rows;
            r_a_sel.root     <= (in_item.node == '0);
            r_a_sel.pvalid   <= (int'(in_item.parent) < MAX_NODES);
            r_a_wr           <= (int'(in_item.node) < MAX_NODES);
        end
        if (a_move) begin
            r_p_node <= r_a_node;
            r_p_col  <= r_a_col;
            r_p_wr   <= r_a_wr;
        end
        if (p_move) begin
            r_out.node <= r_p_node;
            r_out.col  <= r_p_col;
            r_out.rows <= world;
            r_out_sat  <= sat;
        end
        if (wr.en) begin
            r_wb_node <= r_p_node;
            r_wb_col  <= r_p_col;
            r_wb_data <= world;
        end
    end

    always_comb begin
        fwd.valid = r_wb_valid;
        fwd.node  = r_wb_node;
        fwd.col   = r_wb_col;
        fwd.data  = r_wb_data;
    end

    hwt_store #(
        .MAX_NODES (MAX_NODES)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .i_wr      (wr),
        .i_wr_addr (AW'(r_p_node)),
        .i_wr_data (world),
        .o_rd_data (rd_data),
        .o_busy    (busy)
    );

    hwt_mult u_mult (
        .i_clk    (i_clk),
        .i_en     (a_move),
        .i_mat    (rd_data),
        .i_fwd    (fwd),
        .i_parent (r_a_parent),
        .i_sel    (r_a_sel),
        .i_local  (r_a_local),
        .o_prod   (prod)
    );

    hwt_sat u_sat (
        .i_prod  (prod),
        .o_world (world),
        .o_sat   (sat)
    );

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {{(MTdataW - $bits(t_m_item)){1'b0}}, r_out};
    assign m_tuser  = r_out_sat;

endmodule

`default_nettype wire

@@ src/hwt_checker.sv @@
// Port-level checks for the hierarchy world-transform block, bound to the
// top level. Depends on hwt_pkg and hierarchy_world_transform.
`default_nettype none

module hwt_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [hwt_pkg::STdataW-1:0]  s_tdata,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [hwt_pkg::MTdataW-1:0]  m_tdata,
    input logic                         m_tuser
);
    import hwt_pkg::*;

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result word shown straight after reset");

    a_clear_blocks: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !s_tready)
        else $error("word taken before the store sweep");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result word changed");

    a_root_nosat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[7:0] == 8'd0 |-> !m_tuser)
        else $error("root column flagged as saturated");

    a_sat_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser |->
            m_tdata[41:10] == MaxQ || m_tdata[41:10] == MinQ ||
            m_tdata[73:42] == MaxQ || m_tdata[73:42] == MinQ ||
            m_tdata[105:74] == MaxQ || m_tdata[105:74] == MinQ ||
            m_tdata[137:106] == MaxQ || m_tdata[137:106] == MinQ)
        else $error("saturation flag without a clipped element");

endmodule

bind hierarchy_world_transform hwt_checker u_hwt_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking bench for hierarchy_world_transform: directed column table, then random
// node trees and noise words, each result checked against its typed table column or an
// in-bench world-store predictor. Depends on hwt_pkg and the block under src.
`default_nettype none

module tb;

    import hwt_pkg::*;

    localparam int              RUN_LIMIT = 200000;
    localparam int              STORE_N   = DefMaxNodes;
    localparam logic [ElemW-1:0] Neg1     = '1;
    localparam logic [ElemW-1:0] Zero     = '0;

    typedef struct packed {
        logic [NodeW-1:0] node;
        logic [ColW-1:0]  col;
        t_col             rows;
        logic             sat;
    } t_world_col;

    typedef struct packed {
        t_s_item    item;
        logic       typed;
        t_world_col want;
    } t_stim_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [STdataW-1:0]    s_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [MTdataW-1:0]    m_tdata;
    logic                  m_tuser;

    logic [ElemW-1:0]      world_mem [STORE_N][Rows][Rows];
    t_world_col            world_col_expect [$];
    t_stim_row             directed [$];
    int                    send_gap_pct;
    int                    ready_stall_pct;
    int                    fail_count = 0;
    int                    cycle_count = 0;
    t_world_col            got_col;
    t_world_col            want_col;
    t_m_item               got_item;

    hierarchy_world_transform dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_col cols(input logic [ElemW-1:0] r0, input logic [ElemW-1:0] r1,
                                  input logic [ElemW-1:0] r2, input logic [ElemW-1:0] r3);
        t_col c;
        c[0] = r0;
        c[1] = r1;
        c[2] = r2;
        c[3] = r3;
        return c;
    endfunction

    function automatic t_stim_row mk_row(input logic [NodeW-1:0] node,
                                         input logic [NodeW-1:0] parent,
                                         input logic [ColW-1:0] col, input t_col loc,
                                         input logic typed, input t_col want,
                                         input logic want_sat);
        t_stim_row r;
        r.item.node   = node;
        r.item.parent = parent;
        r.item.col    = col;
        r.item.rows   = loc;
        r.typed       = typed;
        r.want.node   = node;
        r.want.col    = col;
        r.want.rows   = want;
        r.want.sat    = want_sat;
        return r;
    endfunction

    function automatic void queue_row(input t_stim_row r);
        directed.insert(directed.size(), r);
    endfunction

    // world column = parent world matrix x local col, Q16.16 floor, clip; root kept
    function automatic t_world_col transform_column(input t_s_item w);
        t_world_col         res;
        logic signed [65:0] acc;
        logic signed [65:0] q;
        logic signed [31:0] pe;
        logic signed [31:0] le;
        res.node = w.node;
        res.col  = w.col;
        res.sat  = 1'b0;
        for (int r = 0; r < Rows; r++) begin
            if (w.node == '0) begin
                res.rows[r] = w.rows[r];
            end else begin
                acc = '0;
                for (int k = 0; k < Rows; k++) begin
                    pe  = world_mem[w.parent][k][r];
                    le  = w.rows[k];
                    acc = acc + pe * le;
                end
                q = acc >>> FracW;
                if (q > 66'sd2147483647) begin
                    res.rows[r] = MaxQ;
                    res.sat     = 1'b1;
                end else if (q < -66'sd2147483648) begin
                    res.rows[r] = MinQ;
                    res.sat     = 1'b1;
                end else begin
                    res.rows[r] = q[ElemW-1:0];
                end
            end
        end
        for (int r = 0; r < Rows; r++)
            world_mem[w.node][w.col][r] = res.rows[r];
        return res;
    endfunction

    function automatic logic [ElemW-1:0] pick_elem();
        case ($urandom_range(15))
            0:       return MaxQ;
            1:       return MinQ;
            2:       return $urandom;
            3:       return 32'($urandom_range(65535));
            4:       return Neg1;
            default: return 32'($urandom_range(4 * 65536)) - 32'(2 * 65536);
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [ElemW-1:0] want,
                                        input logic [ElemW-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    task automatic send_word(input t_s_item w, input logic typed, input t_world_col want);
        t_world_col pred;
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(STdataW - $bits(t_s_item)){1'b0}}, w};
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        pred = transform_column(w);
        world_col_expect.insert(world_col_expect.size(), typed ? want : pred);
        @(negedge i_clk);
    endtask

    task automatic send_random(input int gap_pct, input int stall_pct, input int n_words);
        int               sent;
        int               n;
        logic [NodeW-1:0] base;
        logic [NodeW-1:0] nodes [8];
        logic [NodeW-1:0] parent;
        t_s_item          w;
        send_gap_pct    = gap_pct;
        ready_stall_pct = stall_pct;
        sent            = 0;
        while (sent < n_words) begin
            if ($urandom_range(99) < 80) begin
                // small tree: increasing node indices, later parents from earlier nodes
                n    = $urandom_range(2, 8);
                base = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(255 - n));
                for (int i = 0; i < n; i++)
                    nodes[i] = base + 8'(i);
                for (int i = 0; i < n; i++) begin
                    if (i == 0)
                        parent = 8'($urandom);
                    else if ($urandom_range(1) == 0)
                        parent = nodes[i - 1];
                    else
                        parent = nodes[$urandom_range(i - 1)];
                    for (int c = 0; c < Rows; c++) begin
                        w.node   = nodes[i];
                        w.parent = parent;
                        w.col    = ($urandom_range(9) == 0) ? 2'($urandom) : 2'(c);
                        w.rows   = cols(pick_elem(), pick_elem(), pick_elem(), pick_elem());
                        send_word(w, 1'b0, '0);
                        sent++;
                    end
                end
            end else begin
                w.node   = 8'($urandom);
                w.parent = 8'($urandom);
                w.col    = 2'($urandom);
                w.rows   = cols($urandom, $urandom, $urandom, $urandom);
                send_word(w, 1'b0, '0);
                sent++;
            end
        end
    endtask

    always @(negedge i_clk)
        m_tready <= ($urandom_range(99) >= ready_stall_pct);

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            got_item     = t_m_item'(m_tdata[$bits(t_m_item)-1:0]);
            got_col.node = got_item.node;
            got_col.col  = got_item.col;
            got_col.rows = got_item.rows;
            got_col.sat  = m_tuser;
            if (world_col_expect.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %h", $time, got_col);
                fail_count++;
            end else begin
                want_col = world_col_expect.pop_front();
                check_field("out_node", 32'(want_col.node), 32'(got_col.node));
                check_field("out_column", 32'(want_col.col), 32'(got_col.col));
                check_field("world_row0", want_col.rows[0], got_col.rows[0]);
                check_field("world_row1", want_col.rows[1], got_col.rows[1]);
                check_field("world_row2", want_col.rows[2], got_col.rows[2]);
                check_field("world_row3", want_col.rows[3], got_col.rows[3]);
                check_field("saturated", 32'(want_col.sat), 32'(got_col.sat));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        send_gap_pct    = 0;
        ready_stall_pct = 0;
        for (int n = 0; n < STORE_N; n++)
            for (int c = 0; c < Rows; c++)
                for (int r = 0; r < Rows; r++)
                    world_mem[n][c][r] = '0;

        queue_row(mk_row(8'd5, 8'd3, 2'd0, cols(32'h1234_5678, MinQ, MaxQ, Neg1),
                         1'b1, cols(Zero, Zero, Zero, Zero), 1'b0));
        queue_row(mk_row(8'd0, 8'd0, 2'd0, cols(MaxQ, MinQ, Zero, One),
                         1'b1, cols(MaxQ, MinQ, Zero, One), 1'b0));
        queue_row(mk_row(8'd0, 8'd77, 2'd1, cols(Neg1, 32'd1, MinQ, MaxQ),
                         1'b1, cols(Neg1, 32'd1, MinQ, MaxQ), 1'b0));
        queue_row(mk_row(8'd0, 8'd0, 2'd2, cols(Zero, Zero, One, Zero),
                         1'b1, cols(Zero, Zero, One, Zero), 1'b0));
        queue_row(mk_row(8'd0, 8'd0, 2'd3, cols(Zero, Zero, Zero, One),
                         1'b1, cols(Zero, Zero, Zero, One), 1'b0));
        queue_row(mk_row(8'd1, 8'd0, 2'd0, cols(One, Zero, Zero, Zero),
                         1'b1, cols(MaxQ, MinQ, Zero, One), 1'b0));
        queue_row(mk_row(8'd1, 8'd0, 2'd1, cols(MaxQ, MaxQ, Zero, Zero),
                         1'b0, '0, 1'b0));
        queue_row(mk_row(8'd1, 8'd0, 2'd2, cols(MinQ, MinQ, MinQ, MinQ),
                         1'b0, '0, 1'b0));
        queue_row(mk_row(8'd1, 8'd0, 2'd3, cols(Zero, Zero, Zero, One),
                         1'b1, cols(Zero, Zero, Zero, One), 1'b0));
        queue_row(mk_row(8'd6, 8'd0, 2'd3, cols(Zero, Zero, Zero, Neg1),
                         1'b1, cols(Zero, Zero, Zero, Neg1), 1'b0));
        queue_row(mk_row(8'd2, 8'd1, 2'd0, cols(One, One, One, One),
                         1'b0, '0, 1'b0));
        queue_row(mk_row(8'd3, 8'd2, 2'd0,
                         cols(32'h0001_8000, Neg1, 32'd1, 32'hFFFE_0000),
                         1'b0, '0, 1'b0));
        queue_row(mk_row(8'd1, 8'd1, 2'd0, cols(Zero, One, Zero, Zero),
                         1'b0, '0, 1'b0));
        queue_row(mk_row(8'd4, 8'd200, 2'd2, cols(MaxQ, MinQ, One, Neg1),
                         1'b1, cols(Zero, Zero, Zero, Zero), 1'b0));
        queue_row(mk_row(8'd255, 8'd0, 2'd3, cols(MaxQ, MaxQ, MaxQ, MaxQ),
                         1'b0, '0, 1'b0));
        queue_row(mk_row(8'd255, 8'd255, 2'd3, cols(One, One, One, One),
                         1'b0, '0, 1'b0));
        queue_row(mk_row(8'd128, 8'd255, 2'd1, cols(32'h0000_8000, MinQ, Zero, One),
                         1'b0, '0, 1'b0));

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i])
            send_word(directed[i].item, directed[i].typed, directed[i].want);

        send_random(53, 0, 135);
        send_random(0, 53, 135);
        send_random(17, 17, 135);
        send_random(0, 0, 135);
        s_tvalid <= 1'b0;

        while (world_col_expect.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
src/hwt_pkg.sv
src/hwt_store.sv
src/hwt_mult.sv
src/hwt_sat.sv
src/hierarchy_world_transform.sv
src/hwt_checker.sv
tb/tb.sv
